[src/ghcs_pkg.sv]
// shared types and constants of the grey histogram contrast stretch block
`timescale 1ns / 1ps

package ghcs_pkg;

  // fixed field widths
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned OUT_CNT_W = 20;
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned NUM_BINS = 256;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [FREQ_W-1:0]  FREQ_MAX  = 16'hFFFF;

  // request opcodes
  typedef enum logic [OP_W-1:0] {
    OP_CLEAR   = 2'd0,
    OP_ADD     = 2'd1,
    OP_READ    = 2'd2,
    OP_STRETCH = 2'd3
  } op_e;

  // one queued request
  typedef struct packed {
    op_e                op;
    logic [LEVEL_W-1:0] level;
  } item_t;

  // one result, last field in the lowest bits
  typedef struct packed {
    logic [OUT_CNT_W-1:0] pixel_total;
    logic [LEVEL_W-1:0]   stretched_level;
    logic [LEVEL_W-1:0]   max_level;
    logic [LEVEL_W-1:0]   min_level;
    logic [FREQ_W-1:0]    peak_frequency;
    logic [FREQ_W-1:0]    bin_frequency;
    logic [OUT_CNT_W-1:0] bin_count;
  } result_t;

  localparam int unsigned RES_W = $bits(result_t);

endpackage

[src/ghcs_front.sv]
// front end: request acceptance, opcode decode and a two-entry queue
`timescale 1ns / 1ps

module ghcs_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_valid_i,
  output logic                            s_ready_o,
  input  logic [ghcs_pkg::OP_W-1:0]       s_op_i,
  input  logic [ghcs_pkg::LEVEL_W-1:0]    s_level_i,
  output logic                            q_valid_o,
  input  logic                            q_ready_i,
  output ghcs_pkg::item_t                 q_item_o
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = $clog2(QDEPTH);
  localparam int unsigned CNT_W  = $clog2(QDEPTH + 1);

  ghcs_pkg::item_t   buf_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              push, pop;
  ghcs_pkg::item_t   in_item;

  // decode the incoming request
  always_comb begin
    in_item.op    = ghcs_pkg::op_e'(s_op_i);
    in_item.level = s_level_i;
  end

  assign s_ready_o = (cnt_q != CNT_W'(QDEPTH));
  assign q_valid_o = (cnt_q != '0);
  assign q_item_o  = buf_q[rd_ptr_q];
  assign push      = s_valid_i && s_ready_o;
  assign pop       = q_valid_o && q_ready_i;

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= in_item;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

endmodule

[src/ghcs_divider.sv]
// shared restoring divider, one quotient bit per cycle, saturated to 16 bits
`timescale 1ns / 1ps

module ghcs_divider #(
  parameter int unsigned DEN_W = 20,
  parameter int unsigned NUM_W = 36
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [NUM_W-1:0]               dividend_i,
  input  logic [DEN_W-1:0]               divisor_i,
  output logic                           done_o,
  output logic [ghcs_pkg::FREQ_W-1:0]    quotient_o
);

  localparam int unsigned CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_q, den_q, rem_nx;
  logic [NUM_W-1:0] quo_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DEN_W:0]   rem_sh, diff;
  logic             take;

  // one restoring step
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    diff   = rem_sh - {1'b0, den_q};
    take   = (rem_sh >= {1'b0, den_q});
    rem_nx = take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      den_q  <= '0;
      quo_q  <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q  <= '0;
        quo_q  <= dividend_i;
        den_q  <= divisor_i;
        cnt_q  <= CNT_W'(NUM_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q <= rem_nx;
        quo_q <= {quo_q[NUM_W-2:0], take};
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // saturate the quotient to Q0.16
  assign done_o     = done_q;
  assign quotient_o = (|quo_q[NUM_W-1:ghcs_pkg::FREQ_W]) ? ghcs_pkg::FREQ_MAX
                                                         : quo_q[ghcs_pkg::FREQ_W-1:0];

endmodule

[src/ghcs_back.sv]
// back end: histogram store, statistics, division sequencing and result register
`timescale 1ns / 1ps

module ghcs_back #(
  parameter int unsigned COUNT_BITS = 20,
  parameter int unsigned DIV_W      = 36
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_valid_i,
  output logic                           q_ready_o,
  input  ghcs_pkg::item_t                q_item_i,
  output logic                           div_start_o,
  output logic [DIV_W-1:0]               div_dividend_o,
  output logic [COUNT_BITS-1:0]          div_divisor_o,
  input  logic                           div_done_i,
  input  logic [ghcs_pkg::FREQ_W-1:0]    div_quo_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output ghcs_pkg::result_t              m_result_o
);

  localparam int unsigned LW  = ghcs_pkg::LEVEL_W;
  localparam int unsigned OCW = ghcs_pkg::OUT_CNT_W;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_PEAK,
    S_PEAK_WAIT,
    S_AUX,
    S_AUX_WAIT,
    S_OUT
  } state_e;

  state_e                       state_q;
  logic [COUNT_BITS-1:0]        mem [ghcs_pkg::NUM_BINS];
  logic [COUNT_BITS-1:0]        rd_q;
  logic [ghcs_pkg::NUM_BINS-1:0] vld_q;
  ghcs_pkg::op_e                op_q;
  logic [LW-1:0]                lvl_q, lo_q, hi_q, st_q;
  logic [COUNT_BITS-1:0]        total_q, peak_q, bc_q;
  logic [ghcs_pkg::FREQ_W-1:0]  pf_q, bf_q;
  logic                         aux_q;
  logic                         div_start_q;
  logic [DIV_W-1:0]             div_a_q;
  logic [COUNT_BITS-1:0]        div_b_q;
  logic                         m_vld_q;
  ghcs_pkg::result_t            m_res_q;

  logic [COUNT_BITS-1:0]        cur_cnt, new_cnt, tot_inc;
  logic                         mem_we, mem_re;
  logic                         rng_ok, in_span, at_top;
  logic [LW-1:0]                diff8, range8;
  logic [2*LW-1:0]              num16;
  logic [DIV_W+2*LW-1:0]        num_ext;
  logic [COUNT_BITS+LW-1:0]     rng_ext;
  logic [COUNT_BITS+OCW-1:0]    bc_ext, tot_ext;

  // current bin count and saturating increments
  always_comb begin
    cur_cnt = vld_q[lvl_q] ? rd_q : '0;
    new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + COUNT_BITS'(1);
    tot_inc = (total_q == CNT_MAX) ? total_q : total_q + COUNT_BITS'(1);
    mem_we  = (state_q == S_EXEC) && (op_q == ghcs_pkg::OP_ADD);
    mem_re  = (state_q == S_IDLE) && q_valid_i;
  end

  // stretch operands
  always_comb begin
    rng_ok  = (hi_q > lo_q);
    in_span = rng_ok && (lvl_q > lo_q) && (lvl_q < hi_q);
    at_top  = rng_ok && (lvl_q >= hi_q);
    diff8   = lvl_q - lo_q;
    range8  = hi_q - lo_q;
    num16   = {diff8, {LW{1'b0}}} - {{LW{1'b0}}, diff8};
    num_ext = {{DIV_W{1'b0}}, num16};
    rng_ext = {{COUNT_BITS{1'b0}}, range8};
    bc_ext  = {{OCW{1'b0}}, bc_q};
    tot_ext = {{OCW{1'b0}}, total_q};
  end

  // histogram store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[lvl_q] <= new_cnt;
    end
    if (mem_re) begin
      rd_q <= mem[q_item_i.level];
    end
  end

  // sequencer, statistics and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vld_q       <= '0;
      op_q        <= ghcs_pkg::OP_CLEAR;
      lvl_q       <= '0;
      lo_q        <= ghcs_pkg::LEVEL_MAX;
      hi_q        <= '0;
      total_q     <= '0;
      peak_q      <= '0;
      bc_q        <= '0;
      st_q        <= '0;
      pf_q        <= '0;
      bf_q        <= '0;
      aux_q       <= 1'b0;
      div_start_q <= 1'b0;
      div_a_q     <= '0;
      div_b_q     <= '0;
      m_vld_q     <= 1'b0;
      m_res_q     <= '0;
    end else begin
      // divider start pulse
      div_start_q <= ((state_q == S_PEAK) && (total_q != '0)) || (state_q == S_AUX);
      // result valid flag
      if ((state_q == S_OUT) && (!m_vld_q || m_ready_i)) begin
        m_vld_q <= 1'b1;
      end else if (m_vld_q && m_ready_i) begin
        m_vld_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            op_q    <= q_item_i.op;
            lvl_q   <= q_item_i.level;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          unique case (op_q)
            ghcs_pkg::OP_CLEAR: begin
              vld_q   <= '0;
              total_q <= '0;
              lo_q    <= ghcs_pkg::LEVEL_MAX;
              hi_q    <= '0;
              peak_q  <= '0;
            end
            ghcs_pkg::OP_ADD: begin
              vld_q[lvl_q] <= 1'b1;
              total_q      <= tot_inc;
              if (new_cnt > peak_q) begin
                peak_q <= new_cnt;
              end
              if (lvl_q < lo_q) begin
                lo_q <= lvl_q;
              end
              if (lvl_q > hi_q) begin
                hi_q <= lvl_q;
              end
            end
            ghcs_pkg::OP_READ, ghcs_pkg::OP_STRETCH: begin
            end
            default: begin
            end
          endcase
          bc_q  <= (op_q == ghcs_pkg::OP_READ) ? cur_cnt : '0;
          bf_q  <= '0;
          st_q  <= ((op_q == ghcs_pkg::OP_STRETCH) && at_top) ? ghcs_pkg::LEVEL_MAX : '0;
          aux_q <= ((op_q == ghcs_pkg::OP_READ) && (total_q != '0)) ||
                   ((op_q == ghcs_pkg::OP_STRETCH) && in_span);
          state_q <= S_PEAK;
        end
        S_PEAK: begin
          if (total_q == '0) begin
            pf_q    <= '0;
            state_q <= aux_q ? S_AUX : S_OUT;
          end else begin
            div_a_q     <= {peak_q, {ghcs_pkg::FRAC_W{1'b0}}};
            div_b_q     <= total_q;
            state_q     <= S_PEAK_WAIT;
          end
        end
        S_PEAK_WAIT: begin
          if (div_done_i) begin
            pf_q    <= div_quo_i;
            state_q <= aux_q ? S_AUX : S_OUT;
          end
        end
        S_AUX: begin
          if (op_q == ghcs_pkg::OP_READ) begin
            div_a_q <= {bc_q, {ghcs_pkg::FRAC_W{1'b0}}};
            div_b_q <= total_q;
          end else begin
            div_a_q <= num_ext[DIV_W-1:0];
            div_b_q <= rng_ext[COUNT_BITS-1:0];
          end
          state_q     <= S_AUX_WAIT;
        end
        S_AUX_WAIT: begin
          if (div_done_i) begin
            if (op_q == ghcs_pkg::OP_READ) begin
              bf_q <= div_quo_i;
            end else begin
              st_q <= div_quo_i[LW-1:0];
            end
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_vld_q || m_ready_i) begin
            m_res_q.bin_count       <= bc_ext[OCW-1:0];
            m_res_q.bin_frequency   <= bf_q;
            m_res_q.peak_frequency  <= pf_q;
            m_res_q.min_level       <= lo_q;
            m_res_q.max_level       <= hi_q;
            m_res_q.stretched_level <= st_q;
            m_res_q.pixel_total     <= tot_ext[OCW-1:0];
            state_q                 <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign q_ready_o      = (state_q == S_IDLE);
  assign div_start_o    = div_start_q;
  assign div_dividend_o = div_a_q;
  assign div_divisor_o  = div_b_q;
  assign m_valid_o      = m_vld_q;
  assign m_result_o     = m_res_q;

endmodule

[src/grey_histogram_contrast_stretch.sv]
// top level of the grey histogram contrast stretch block
`timescale 1ns / 1ps
// Grey-level histogram with statistics and contrast stretch.
// Slave stream: tuser carries the opcode (clear, add pixel, read bin, stretch),
// tdata carries the grey level or bin index. Every request gives one result on
// the master stream with the bin count and frequency (read only), the peak
// frequency, min and max level, the stretched level (stretch only) and the
// pixel total, all as they stand after the request.
// Requests enter a two-entry queue and are executed one at a time by a
// sequencer in front of a 256-entry count memory. A request passes the
// execute and peak states, then the peak frequency division whenever the
// total is nonzero, then a second division for a read bin with a nonzero
// total or for a stretch of a level strictly between min and max, and ends in
// the output state; both divisions use the shared bit-serial divider. Reset
// clears the histogram (per-bin valid flags), the statistics and the queue at
// once; there is no clearing pass. When the receiver stalls the finished
// result stays in the output register and the queue keeps accepting until
// it holds two requests.
module grey_histogram_contrast_stretch #(
  parameter int unsigned COUNT_BITS = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // level[7:0]
  input  logic [1:0]                   s_axis_tuser_i,  // opcode[1:0]
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // bin_count[19:0], bin_frequency[35:20], peak_frequency[51:36],
  // min_level[59:52], max_level[67:60], stretched_level[75:68], pixel_total[95:76]
  output logic [ghcs_pkg::RES_W-1:0]   m_axis_tdata_o
);

  localparam int unsigned DIV_W = COUNT_BITS + ghcs_pkg::FRAC_W;

  logic                         q_valid, q_ready;
  ghcs_pkg::item_t              q_item;
  logic                         div_start, div_done;
  logic [DIV_W-1:0]             div_dividend;
  logic [COUNT_BITS-1:0]        div_divisor;
  logic [ghcs_pkg::FREQ_W-1:0]  div_quo;
  ghcs_pkg::result_t            m_result;

  // request queue
  ghcs_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .s_op_i    (s_axis_tuser_i),
    .s_level_i (s_axis_tdata_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  // execution and result register
  ghcs_back #(
    .COUNT_BITS (COUNT_BITS),
    .DIV_W      (DIV_W)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_ready_o      (q_ready),
    .q_item_i       (q_item),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quo_i      (div_quo),
    .m_valid_o      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_result_o     (m_result)
  );

  // shared divider
  ghcs_divider #(
    .DEN_W (COUNT_BITS),
    .NUM_W (DIV_W)
  ) u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  assign m_axis_tdata_o = m_result;

endmodule

[src/ghcs_checker.sv]
// port-level checks on the result stream, bound to the top level
`timescale 1ns / 1ps

module ghcs_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [ghcs_pkg::RES_W-1:0]  m_tdata_i
);

  ghcs_pkg::result_t res;
  assign res = m_tdata_i;

  // a result stays offered until taken
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result withdrawn before it was taken");

  // a stalled result keeps its bits
  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> $stable(m_tdata_i))
    else $error("stalled result changed");

  // a nonzero stretch needs a positive range
  a_stretch_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (res.stretched_level != '0) |-> (res.max_level > res.min_level))
    else $error("stretched level nonzero with empty range");

  // an empty bin has zero frequency
  a_empty_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && (res.bin_count == '0) |-> (res.bin_frequency == '0))
    else $error("empty bin with nonzero frequency");

endmodule

bind grey_histogram_contrast_stretch ghcs_checker u_ghcs_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);
